[design/wps_pkg.sv]
// wps_pkg: shared types, constants and helpers of the wave pcm stream writer
// used by the front, queue, back and top level files; depends on nothing
`default_nettype none

package wps_pkg;

  // structure sizes
  localparam int MAX_CHANNELS  = 4;
  localparam int SAMPLE_FIELDS = 4;
  localparam int CH_W          = $clog2(SAMPLE_FIELDS);
  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int S_TDATA_W     = 136;
  localparam int M_TDATA_W     = 8;

  // configuration register indexes
  localparam logic [1:0] CFG_SAMPLE_RATE   = 2'd0;
  localparam logic [1:0] CFG_DEPTH_CODE    = 2'd1;
  localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd2;
  localparam logic [1:0] CFG_DURATION      = 2'd3;

  // configuration reset values
  localparam logic [31:0] RST_SAMPLE_RATE   = 32'd44100;
  localparam logic [1:0]  RST_DEPTH_CODE    = 2'd1;
  localparam logic [2:0]  RST_CHANNEL_COUNT = 3'd2;
  localparam logic [31:0] RST_DURATION      = 32'd1;

  // depth codes
  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

  // input opcodes
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_FRAME  = 1'b1;

  // work kinds between issue and queue push
  localparam logic [2:0] KIND_FRAMES = 3'd0;
  localparam logic [2:0] KIND_DSIZE  = 3'd1;
  localparam logic [2:0] KIND_RATE   = 3'd2;
  localparam logic [2:0] KIND_WORD   = 3'd3;
  localparam logic [2:0] KIND_SAMPLE = 3'd4;
  localparam logic [2:0] KIND_ERR    = 3'd5;

  // sequencer modes
  localparam logic [1:0] MODE_HDR = 2'd0;
  localparam logic [1:0] MODE_FRM = 2'd1;
  localparam logic [1:0] MODE_ERR = 2'd2;

  // header step indexes
  localparam logic [3:0] HDR_FIRST_WORD = 4'd3;
  localparam logic [3:0] HDR_LAST_STEP  = 4'd15;

  // fixed point one in q2.30, and header tags as little-endian words
  localparam logic [31:0] Q_ONE    = 32'h4000_0000;
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [31:0] RIFF_EXTRA = 32'd36;
  localparam logic [31:0] FMT_SIZE   = 32'd16;
  localparam logic [31:0] FMT_PCM    = 32'd1;
  localparam logic [31:0] SCALE_U8   = 32'd255;

  typedef struct packed {
    logic [31:0] sample_rate;
    logic [1:0]  depth_code;
    logic [2:0]  channel_count;
    logic [31:0] duration_seconds;
  } wps_cfg_t;

  // one queued word: value, byte count minus one, end of item, error flag
  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  nbm1;
    logic        last;
    logic        err;
  } wps_entry_t;

  // full scale of the signed depths, and 255 for the unsigned 8-bit depth
  function automatic logic [31:0] amp_for_depth(input logic [1:0] depth);
    logic [31:0] amp;
    case (depth)
      DEPTH_16: amp = 32'd32767;
      DEPTH_24: amp = 32'd8388607;
      DEPTH_32: amp = 32'd2147483647;
      default:  amp = SCALE_U8;
    endcase
    return amp;
  endfunction

endpackage

`default_nettype wire

[design/wps_front.sv]
// wps_front: accepts items, classifies them and issues one step a cycle while
// the queue has room, through a shared registered multiplier; depends on wps_pkg
`default_nettype none

module wps_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire wps_pkg::wps_cfg_t              cfg,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // frame_channels[2:0], sample_0[34:3], sample_1[66:35], sample_2[98:67],
  // sample_3[130:99], zero fill
  input  wire logic [wps_pkg::S_TDATA_W-1:0]  s_tdata,
  // opcode
  input  wire logic                           s_tuser,
  input  wire logic [wps_pkg::QCNT_W-1:0]     q_count,
  output logic                                q_push,
  output wps_pkg::wps_entry_t                 q_entry
);
  import wps_pkg::*;

  // sequencer state
  logic        busy;
  logic [1:0]  mode;
  logic [3:0]  idx;
  logic [3:0]  last_idx;
  logic [31:0] samp [SAMPLE_FIELDS];

  // product stage
  logic        p_valid;
  logic [2:0]  p_kind;
  logic [63:0] p_prod;
  logic        p_neg;
  logic [1:0]  p_nbm1;
  logic        p_last;

  // header values kept for the word steps
  logic [31:0] dsize;
  logic [31:0] rate;

  logic [2:0]  fch;
  logic        in_empty;
  logic        in_err;
  logic        accept;
  logic [2:0]  bytes_per;
  logic [5:0]  align_w;
  logic [15:0] align;
  logic [15:0] bits;

  logic [31:0] raw;
  logic        neg;
  logic [31:0] mag_full;
  logic [31:0] mag;
  logic [31:0] shifted;

  logic [2:0]  iss_kind;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] word;
  logic [1:0]  iss_nbm1;
  logic        op_push;
  logic        op_last;
  logic        credit;
  logic        can_issue;
  logic        use_word;
  logic [63:0] prod;
  logic [31:0] q_mag;

  // item classification
  always_comb begin
    fch       = s_tdata[2:0];
    in_empty  = (cfg.channel_count == 3'd0) && (fch == 3'd0);
    in_err    = (fch != cfg.channel_count) ||
                (cfg.channel_count > 3'(MAX_CHANNELS));
    bytes_per = {1'b0, cfg.depth_code} + 3'd1;
    align_w   = 6'(cfg.channel_count) * 6'(bytes_per);
    align     = {10'b0, align_w};
    bits      = {10'b0, bytes_per, 3'b000};
  end

  // sample clamp and offset ahead of the multiplier
  always_comb begin
    raw      = samp[idx[CH_W-1:0]];
    neg      = raw[31];
    mag_full = neg ? (~raw + 32'd1) : raw;
    mag      = (mag_full > Q_ONE) ? Q_ONE : mag_full;
    shifted  = neg ? (Q_ONE - mag) : (Q_ONE + mag);
  end

  // operation of the current step
  always_comb begin
    iss_kind = KIND_ERR;
    mul_a    = 32'd0;
    mul_b    = 32'd0;
    word     = 32'd0;
    iss_nbm1 = 2'd0;
    case (mode)
      MODE_HDR: begin
        iss_nbm1 = 2'd3;
        iss_kind = KIND_WORD;
        case (idx)
          4'd0: begin
            iss_kind = KIND_FRAMES;
            mul_a    = cfg.sample_rate;
            mul_b    = cfg.duration_seconds;
          end
          4'd1: begin
            iss_kind = KIND_DSIZE;
            mul_a    = p_prod[31:0];
            mul_b    = {16'b0, align};
          end
          4'd2: begin
            iss_kind = KIND_RATE;
            mul_a    = cfg.sample_rate;
            mul_b    = {16'b0, align};
          end
          4'd3:  word = TAG_RIFF;
          4'd4:  word = dsize + RIFF_EXTRA;
          4'd5:  word = TAG_WAVE;
          4'd6:  word = TAG_FMT;
          4'd7:  word = FMT_SIZE;
          4'd8: begin
            word     = FMT_PCM;
            iss_nbm1 = 2'd1;
          end
          4'd9: begin
            word     = {29'b0, cfg.channel_count};
            iss_nbm1 = 2'd1;
          end
          4'd10: word = cfg.sample_rate;
          4'd11: word = rate;
          4'd12: begin
            word     = {16'b0, align};
            iss_nbm1 = 2'd1;
          end
          4'd13: begin
            word     = {16'b0, bits};
            iss_nbm1 = 2'd1;
          end
          4'd14: word = TAG_DATA;
          default: word = dsize;
        endcase
      end
      MODE_FRM: begin
        iss_kind = KIND_SAMPLE;
        iss_nbm1 = cfg.depth_code;
        if (cfg.depth_code == DEPTH_8) begin
          mul_a = shifted;
          mul_b = SCALE_U8;
        end else begin
          mul_a = mag;
          mul_b = amp_for_depth(cfg.depth_code);
        end
      end
      default: begin
        iss_kind = KIND_ERR;
      end
    endcase
  end

  // issue gating: pushing steps need room for themselves and the word in flight
  always_comb begin
    op_push   = !((mode == MODE_HDR) && (idx < HDR_FIRST_WORD));
    op_last   = (idx == last_idx);
    credit    = (q_count + QCNT_W'(q_push)) < QCNT_W'(QUEUE_DEPTH);
    can_issue = busy && (!op_push || credit);
    s_tready  = !busy || (can_issue && op_last);
    accept    = s_tvalid && s_tready;
    use_word  = (iss_kind == KIND_WORD) || (iss_kind == KIND_ERR);
    prod      = mul_a * mul_b;
  end

  // word handed to the queue from the product stage
  always_comb begin
    q_push        = p_valid && ((p_kind == KIND_WORD) || (p_kind == KIND_SAMPLE) ||
                                (p_kind == KIND_ERR));
    q_mag         = p_prod[61:30];
    q_entry.nbm1  = p_nbm1;
    q_entry.last  = p_last;
    q_entry.err   = (p_kind == KIND_ERR);
    q_entry.value = p_prod[31:0];
    if (p_kind == KIND_SAMPLE) begin
      if (cfg.depth_code == DEPTH_8) begin
        q_entry.value = {24'b0, p_prod[38:31]};
      end else begin
        q_entry.value = p_neg ? (32'd0 - q_mag) : q_mag;
      end
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      p_valid <= 1'b0;
    end else begin
      p_valid <= can_issue;
      if (accept) begin
        busy <= (s_tuser == OP_HEADER) || !in_empty;
      end else if (can_issue && op_last) begin
        busy <= 1'b0;
      end
    end
  end

  // sequencer and product payload
  always_ff @(posedge clk) begin
    if (accept) begin
      idx <= 4'd0;
      if (s_tuser == OP_HEADER) begin
        mode     <= MODE_HDR;
        last_idx <= HDR_LAST_STEP;
      end else if (in_err) begin
        mode     <= MODE_ERR;
        last_idx <= 4'd0;
      end else begin
        mode     <= MODE_FRM;
        last_idx <= 4'(cfg.channel_count) - 4'd1;
      end
      for (int i = 0; i < SAMPLE_FIELDS; i++) begin
        samp[i] <= s_tdata[3 + 32*i +: 32];
      end
    end else if (can_issue) begin
      idx <= idx + 4'd1;
    end
    if (can_issue) begin
      p_kind <= iss_kind;
      p_prod <= use_word ? {32'b0, word} : prod;
      p_neg  <= neg;
      p_nbm1 <= iss_nbm1;
      p_last <= op_last;
    end
    if (p_valid && (p_kind == KIND_DSIZE)) begin
      dsize <= p_prod[31:0];
    end
    if (p_valid && (p_kind == KIND_RATE)) begin
      rate <= p_prod[31:0];
    end
  end

endmodule

`default_nettype wire

[design/wps_queue.sv]
// wps_queue: short word queue between front and back
// holds wps_pkg::wps_entry_t words; depends on wps_pkg
`default_nettype none

module wps_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       push,
  input  wire wps_pkg::wps_entry_t        push_entry,
  input  wire logic                       pop,
  output logic                            head_valid,
  output wps_pkg::wps_entry_t             head_entry,
  output logic [wps_pkg::QCNT_W-1:0]      count
);
  import wps_pkg::*;

  wps_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  // head of the queue
  always_comb begin
    head_valid = (count != '0);
    head_entry = slots[rd_ptr];
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[design/wps_back.sv]
// wps_back: splits queued words into little-endian byte beats
// behind a registered output stage; depends on wps_pkg
`default_nettype none

module wps_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          q_valid,
  input  wire wps_pkg::wps_entry_t           q_entry,
  output logic                               q_pop,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // out_byte[7:0]
  output logic [wps_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                               m_tlast,
  // frame_error
  output logic                               m_tuser
);
  import wps_pkg::*;

  logic        cur_valid;
  logic [31:0] cur_val;
  logic [1:0]  cur_rem;
  logic        cur_last;
  logic        cur_err;
  logic        out_load;
  logic        cur_done;

  // byte transfer and word refill
  always_comb begin
    out_load = cur_valid && (!m_tvalid || m_tready);
    cur_done = out_load && (cur_rem == 2'd0);
    q_pop    = q_valid && (!cur_valid || cur_done);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_valid <= 1'b1;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= cur_val[7:0];
      m_tlast <= cur_last && (cur_rem == 2'd0);
      m_tuser <= cur_err;
    end
    if (q_pop) begin
      cur_val  <= q_entry.value;
      cur_rem  <= q_entry.nbm1;
      cur_last <= q_entry.last;
      cur_err  <= q_entry.err;
    end else if (out_load) begin
      cur_val <= {8'b0, cur_val[31:8]};
      cur_rem <= cur_rem - 2'd1;
    end
  end

endmodule

`default_nettype wire

[design/wav_pcm_stream_writer_unit.sv]
// wav_pcm_stream_writer_unit: top level, configuration registers and the
// front, queue and back parts; depends on wps_pkg, wps_front, wps_queue, wps_back
// throughput: one output byte a cycle while m_tready is high and words are
//   queued; a valid frame gives channel_count * (depth_code+1) bytes, a header
//   44 bytes from its 16 sequencer steps; the front takes the next item as it
//   issues the last word of the current one, bounded by the 4-word queue
// reset: rst, synchronous, active high; clears the queue, sequencer and output
//   stage and loads 44100 Hz, 16-bit, 2 channels, 1 second
`default_nettype none

module wav_pcm_stream_writer_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [31:0]                   cfg_data,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // frame_channels[2:0], sample_0[34:3], sample_1[66:35], sample_2[98:67],
  // sample_3[130:99], zero fill
  input  wire logic [wps_pkg::S_TDATA_W-1:0] s_tdata,
  // opcode
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // out_byte[7:0]
  output logic [wps_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic                               m_tlast,
  // frame_error
  output logic                               m_tuser
);
  import wps_pkg::*;

  wps_cfg_t          cfg;
  logic              q_push;
  wps_entry_t        q_in;
  logic              q_pop;
  logic              q_valid;
  wps_entry_t        q_head;
  logic [QCNT_W-1:0] q_count;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_rate      <= RST_SAMPLE_RATE;
      cfg.depth_code       <= RST_DEPTH_CODE;
      cfg.channel_count    <= RST_CHANNEL_COUNT;
      cfg.duration_seconds <= RST_DURATION;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_RATE:   cfg.sample_rate      <= cfg_data;
        CFG_DEPTH_CODE:    cfg.depth_code       <= cfg_data[1:0];
        CFG_CHANNEL_COUNT: cfg.channel_count    <= cfg_data[2:0];
        CFG_DURATION:      cfg.duration_seconds <= cfg_data;
        default:           cfg                  <= cfg;
      endcase
    end
  end

  wps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_entry  (q_in)
  );

  wps_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head),
    .count      (q_count)
  );

  wps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_entry  (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

[design/wps_checker.sv]
// wps_checker: port-level checks of the wave pcm stream writer over time
// bound to wav_pcm_stream_writer_unit; depends on nothing else
`default_nettype none

module wps_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic       m_tuser
);

  // output stage is empty straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output beat valid after reset");

  // front is free to take an item straight after reset
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready after reset");

  // a stalled beat holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
                              $stable(m_tuser))
    else $error("stalled output beat changed");

  // an error beat carries a zero byte and closes its item
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata == 8'd0) && m_tlast)
    else $error("error beat not zero or not last");

endmodule

bind wav_pcm_stream_writer_unit wps_checker u_wps_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[sim/wav_pcm_stream_writer_unit_test.sv]
`timescale 1ns / 1ps
// wav_pcm_stream_writer_unit_test: self-checking bench for the wave pcm stream writer,
// predicting every header and sample byte and checking the output stream in order
// depends on wps_pkg and the wav_pcm_stream_writer_unit design files

module wav_pcm_stream_writer_unit_test;
  import wps_pkg::*;

  localparam int SETTLE_CYCLES   = 32;
  localparam int STALL_LIMIT     = 4000;
  localparam int LONG_HOLD       = 300;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 33;
  localparam int MAX_REPORTS     = 30;

  localparam logic [31:0] UNITY_Q        = 32'h4000_0000;
  localparam logic [31:0] RIFF_SIZE_BIAS = 32'd36;
  localparam logic [31:0] FMT_LEN        = 32'd16;
  localparam logic [31:0] PCM_FORMAT     = 32'd1;

  // one input beat before packing
  typedef struct packed {
    logic             opcode;
    logic [2:0]       channels;
    logic [3:0][31:0] samples;
  } pcm_item_t;

  // one output beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } file_byte_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_we    = 1'b0;
  logic [1:0]           cfg_index = CFG_SAMPLE_RATE;
  logic [31:0]          cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  wire                  s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic                 s_tuser   = 1'b0;
  wire                  m_tvalid;
  logic                 m_tready  = 1'b0;
  wire  [7:0]           m_tdata;
  wire                  m_tlast;
  wire                  m_tuser;

  wps_cfg_t   model_cfg;
  pcm_item_t  pending_items[$];
  file_byte_t expected_bytes[$];
  pcm_item_t  offered_item;
  logic       item_offered = 1'b0;
  file_byte_t due_byte;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         rx_hold_left;
  int         error_count;
  int         quiet_cycles;

  wav_pcm_stream_writer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // q2.30 sample to pcm code: clamp to [-1,1], then scale with truncation
  function automatic logic [31:0] pcm_code(input logic [31:0] raw, input logic [1:0] depth);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] full;
    logic [63:0] q;
    logic [31:0] code;
    neg = raw[31];
    mag = neg ? (64'h1_0000_0000 - {32'd0, raw}) : {32'd0, raw};
    if (mag > {32'd0, UNITY_Q}) mag = {32'd0, UNITY_Q};
    if (depth == DEPTH_8) begin
      // offset binary, (c+1)*127.5 rounded down
      q = neg ? ({32'd0, UNITY_Q} - mag) : ({32'd0, UNITY_Q} + mag);
      q = (q * 64'd255) >> 31;
      code = q[31:0];
    end else begin
      case (depth)
        DEPTH_16: full = 64'd32767;
        DEPTH_24: full = 64'd8388607;
        default:  full = 64'd2147483647;
      endcase
      q = (mag * full) >> 30;
      code = neg ? (32'd0 - q[31:0]) : q[31:0];
    end
    return code;
  endfunction

  task automatic push_le(input logic [31:0] value, input int nbytes);
    for (int i = 0; i < nbytes; i++)
      expected_bytes.push_back(file_byte_t'{value[8*i +: 8], 1'b0, 1'b0});
  endtask

  task automatic push_tag(input string tag);
    for (int i = 0; i < 4; i++)
      expected_bytes.push_back(file_byte_t'{tag[i], 1'b0, 1'b0});
  endtask

  // expected byte stream of one accepted beat under the current settings
  task automatic predict_item(input pcm_item_t it);
    logic [31:0] per_sample;
    logic [31:0] align;
    logic [31:0] rate;
    logic [31:0] data_size;
    int          depth_before;
    depth_before = expected_bytes.size();
    per_sample = 32'(model_cfg.depth_code) + 32'd1;
    if (it.opcode == OP_HEADER) begin
      align = (32'(model_cfg.channel_count) * per_sample) & 32'h0000_FFFF;
      rate = model_cfg.sample_rate * align;
      data_size = model_cfg.sample_rate * model_cfg.duration_seconds * align;
      push_tag("RIFF");
      push_le(RIFF_SIZE_BIAS + data_size, 4);
      push_tag("WAVE");
      push_tag("fmt ");
      push_le(FMT_LEN, 4);
      push_le(PCM_FORMAT, 2);
      push_le(32'(model_cfg.channel_count), 2);
      push_le(model_cfg.sample_rate, 4);
      push_le(rate, 4);
      push_le(align, 2);
      push_le(per_sample * 32'd8, 2);
      push_tag("data");
      push_le(data_size, 4);
    end else if (it.channels != model_cfg.channel_count ||
                 model_cfg.channel_count > MAX_CHANNELS) begin
      expected_bytes.push_back(file_byte_t'{8'h00, 1'b0, 1'b1});
    end else begin
      for (int ch = 0; ch < model_cfg.channel_count; ch++)
        push_le(pcm_code(it.samples[ch], model_cfg.depth_code), int'(per_sample));
    end
    // zero channel frames leave nothing to mark
    if (expected_bytes.size() > depth_before) expected_bytes[$].last = 1'b1;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return UNITY_Q;
      2: return 32'hC000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      5: return UNITY_Q - $urandom_range(255);
      6: return 32'd0 - (UNITY_Q - $urandom_range(255));
      7, 8: return $urandom_range(32'h8000_0000) - UNITY_Q;
      default: return $urandom();
    endcase
  endfunction

  function automatic pcm_item_t fixed_frame(input logic [2:0] chans, input logic [31:0] s0,
                                            input logic [31:0] s1, input logic [31:0] s2,
                                            input logic [31:0] s3);
    pcm_item_t it;
    it.opcode = OP_FRAME;
    it.channels = chans;
    it.samples = {s3, s2, s1, s0};
    return it;
  endfunction

  function automatic pcm_item_t random_frame(input logic [2:0] chans);
    return fixed_frame(chans, pick_sample(), pick_sample(), pick_sample(), pick_sample());
  endfunction

  function automatic pcm_item_t header_item();
    pcm_item_t it;
    it = random_frame(3'($urandom_range(4)));
    it.opcode = OP_HEADER;
    return it;
  endfunction

  // mostly well formed frames, some headers, some channel count noise
  function automatic pcm_item_t random_item();
    int roll;
    roll = $urandom_range(99);
    if (roll < 8) return header_item();
    if (roll < 18 || model_cfg.channel_count > 3'd4)
      return random_frame(3'($urandom_range(4)));
    return random_frame(model_cfg.channel_count);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(4))
      0: return 32'd1;
      1: return 32'hFFFF_FFFF;
      2: return 32'd48000;
      default: return $urandom();
    endcase
  endfunction

  // register write, upper data bits left random to check masking
  task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    case (index)
      CFG_SAMPLE_RATE:   model_cfg.sample_rate = value;
      CFG_DEPTH_CODE:    model_cfg.depth_code = value[1:0];
      CFG_CHANNEL_COUNT: model_cfg.channel_count = value[2:0];
      default:           model_cfg.duration_seconds = value;
    endcase
  endtask

  task automatic apply_config(input logic [31:0] rate, input logic [1:0] depth,
                              input logic [2:0] chans, input logic [31:0] secs);
    write_reg(CFG_SAMPLE_RATE, rate);
    write_reg(CFG_DEPTH_CODE, {30'($urandom()), depth});
    write_reg(CFG_CHANNEL_COUNT, {29'($urandom()), chans});
    write_reg(CFG_DURATION, secs);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender pause until every byte is out, then let the block go quiet
  task automatic wait_drained();
    while (pending_items.size() != 0 || item_offered || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_item(offered_item);
        item_offered = 1'b0;
      end
      if (!item_offered) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          offered_item = pending_items.pop_front();
          item_offered = 1'b1;
          s_tvalid <= 1'b1;
          s_tdata <= {5'd0, offered_item.samples, offered_item.channels};
          s_tuser <= offered_item.opcode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected beat, got data %02h last %0b err %0b",
                     $time, m_tdata, m_tlast, m_tuser);
        end else begin
          due_byte = expected_bytes.pop_front();
          if (m_tdata !== due_byte.data || m_tlast !== due_byte.last ||
              m_tuser !== due_byte.err) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("%0t: mismatch, expected data %02h last %0b err %0b, got %02h %0b %0b",
                       $time, due_byte.data, due_byte.last, due_byte.err,
                       m_tdata, m_tlast, m_tuser);
          end
        end
      end
      // long hold-off, counted here, takes priority over random stalls
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    model_cfg = '{32'd44100, 2'd1, 3'd2, 32'd1};
    tx_idle_pct = 16;
    rx_idle_pct = 51;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: header, clamp points, sign extremes, channel mismatches
    pending_items.push_back(header_item());
    pending_items.push_back(fixed_frame(3'd2, 32'h0000_0000, UNITY_Q, 0, 0));
    pending_items.push_back(fixed_frame(3'd2, 32'hC000_0000, 32'h7FFF_FFFF, 0, 0));
    pending_items.push_back(fixed_frame(3'd2, 32'h8000_0000, 32'h0000_0001, 0, 0));
    pending_items.push_back(fixed_frame(3'd2, 32'hFFFF_FFFF, 32'h3FFF_FFFF, 0, 0));
    pending_items.push_back(random_frame(3'd3));
    pending_items.push_back(random_frame(3'd0));
    wait_drained();

    // 8-bit unsigned, four channels, size wraparound
    apply_config(32'd1, DEPTH_8, 3'd4, 32'hFFFF_FFFF);
    pending_items.push_back(header_item());
    pending_items.push_back(fixed_frame(3'd4, UNITY_Q, 32'hC000_0000, 32'h0, 32'h8000_0000));
    pending_items.push_back(fixed_frame(3'd4, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF,
                                        32'h2000_0000));
    wait_drained();

    // 24-bit mono at the largest rate and duration
    apply_config(32'hFFFF_FFFF, DEPTH_24, 3'd1, 32'hFFFF_FFFF);
    pending_items.push_back(header_item());
    pending_items.push_back(fixed_frame(3'd1, UNITY_Q, 0, 0, 0));
    pending_items.push_back(fixed_frame(3'd1, 32'hC000_0000, 0, 0, 0));
    wait_drained();

    // 32-bit, three channels
    apply_config(32'd48000, DEPTH_32, 3'd3, 32'd3600);
    pending_items.push_back(header_item());
    pending_items.push_back(fixed_frame(3'd3, UNITY_Q, 32'hC000_0000, 32'h7FFF_FFFF, 0));
    pending_items.push_back(fixed_frame(3'd3, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF, 0));
    wait_drained();

    // channel count above the sample fields: every frame rejected
    apply_config(32'd44100, DEPTH_16, 3'd5, 32'd1);
    pending_items.push_back(header_item());
    pending_items.push_back(random_frame(3'd4));
    pending_items.push_back(random_frame(3'd0));
    wait_drained();
    apply_config(32'd8000, DEPTH_8, 3'd7, 32'd2);
    pending_items.push_back(header_item());
    wait_drained();

    // zero channels: empty frame gives no beat, others rejected
    apply_config(32'd22050, DEPTH_24, 3'd0, 32'd10);
    pending_items.push_back(header_item());
    pending_items.push_back(random_frame(3'd0));
    pending_items.push_back(random_frame(3'd1));
    wait_drained();

    // random phases, each with fresh settings
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 4) begin
        tx_idle_pct = 16;
        rx_idle_pct = 51;
      end else if (phase < 7) begin
        tx_idle_pct = 51;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (phase == 2) begin
        // receiver blocks while the sender keeps offering, so the input backs up
        apply_config(32'd44100, DEPTH_32, 3'd4, 32'd1);
        rx_hold_left = LONG_HOLD;
      end else begin
        apply_config(pick_word(), 2'($urandom_range(3)),
                     ($urandom_range(9) < 8) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(7)),
                     pick_word());
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) pending_items.push_back(random_item());
      wait_drained();
    end

    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[filelist.f]
design/wps_pkg.sv
design/wps_front.sv
design/wps_queue.sv
design/wps_back.sv
design/wav_pcm_stream_writer_unit.sv
design/wps_checker.sv
sim/wav_pcm_stream_writer_unit_test.sv
